FILE: hw/rtl/arp_receive_cache_update_assert.svh
// ----------------------------------------------------------------------------
// ARP receive cache assertion macros
// Concurrent assertion wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ARP_RECEIVE_CACHE_UPDATE_ASSERT_SVH
`define ARP_RECEIVE_CACHE_UPDATE_ASSERT_SVH

`ifndef SYNTH

// Property that must hold at every clock edge out of reset
`define ARPR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define ARPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ARPR_ASSERT(lbl, prop, msg)
`define ARPR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/arpr_pkg.sv
// ----------------------------------------------------------------------------
// ARP receive cache package
// Shared constants, state encoding and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package arpr_pkg;

    // Field widths
    localparam int OP_W   = 16;
    localparam int MAC_W  = 48;
    localparam int IP_W   = 32;
    localparam int CNT_W  = 5;
    localparam int CFG_W  = 48;
    localparam int IDX_W  = 1;

    // Stream payload widths
    localparam int S_DATA_W = 112;
    localparam int M_DATA_W = 88;

    // ARP operation codes
    localparam logic [OP_W-1:0] OP_REQUEST = 16'd1;
    localparam logic [OP_W-1:0] OP_REPLY   = 16'd2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_LOCAL_IP  = 1'b0;
    localparam logic [IDX_W-1:0] REG_LOCAL_MAC = 1'b1;

    // Reset values of the configuration registers
    localparam logic [IP_W-1:0]  LOCAL_IP_RST  = 32'd2362674795;
    localparam logic [MAC_W-1:0] LOCAL_MAC_RST = 48'd77135695076;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_CHECK,
        ST_FINISH
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture the request
        logic rd_en;     // read cached IP at scan index
        logic inc_idx;   // step scan index
        logic merge_wr;  // overwrite MAC at scan index
        logic commit;    // insert if due, load result register
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic op_ok;     // opcode is request or reply
        logic used_zero; // cache empty
        logic hit;       // read IP equals sender IP
        logic last;      // scan index at final used entry
        logic out_free;  // result register can take a value
    } dp_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/arp_receive_cache_update.sv
// ----------------------------------------------------------------------------
// ARP receive cache update
// RFC 826 reception rule: merge into, or append to, a small IP/MAC cache and
// flag requests to the local address for a reply.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                   Content (lowest bit first)
//  s        s_tvalid/tready/tdata/tuser  tuser: opcode; tdata: sender_mac,
//                                        sender_ip, target_ip
//  m        m_tvalid/tready/tdata/tuser  tuser: reply_valid; tdata:
//                                        reply_target_mac, reply_target_ip,
//                                        merged, inserted, cache_full,
//                                        entry_count
//  cfg      cfg_we/index/data         0 local_ip, 1 local_mac
//
//  A request runs through the start, read/compare and finish states; the scan
//  reads the single-port IP memory one entry per read/compare pair and stops
//  at the first match.
//  The next request is taken as soon as the result is in the output register.
//  A stalled output holds the block in its final state until the register frees.
//  Reset clears the entry count; cache contents need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_receive_cache_update
    import arpr_pkg::*;
#(
    parameter int CACHE_ENTRIES = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // Request stream
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,  // sender_mac, sender_ip, target_ip
    input  wire logic [OP_W-1:0]     s_tuser,  // opcode
    // Result stream
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,  // reply_target_mac, reply_target_ip,
                                               // merged, inserted, cache_full,
                                               // entry_count
    output logic                     m_tuser,  // reply_valid
    // Configuration writes
    input  wire logic                cfg_we,
    input  wire logic [IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_data
);

    logic [IP_W-1:0]  local_ip_reg;
    logic [MAC_W-1:0] local_mac_reg;
    ctrl_cmd_t        cmd;
    dp_status_t       status;

    // Configuration registers; local_mac is held but not used by the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg  <= LOCAL_IP_RST;
            local_mac_reg <= LOCAL_MAC_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LOCAL_IP:  local_ip_reg  <= cfg_data[IP_W-1:0];
                REG_LOCAL_MAC: local_mac_reg <= cfg_data[MAC_W-1:0];
                default:       local_ip_reg  <= local_ip_reg;
            endcase
        end
    end

    arpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    arpr_dpath #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .local_ip  (local_ip_reg),
        .in_opcode (s_tuser),
        .in_data   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/arpr_ctrl.sv
// ----------------------------------------------------------------------------
// ARP receive cache controller
// Sequences capture, cache scan, merge and commit of one request at a time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "arp_receive_cache_update_assert.svh"

module arpr_ctrl
    import arpr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                // ignored opcodes and an empty cache skip the scan
                if (!status.op_ok || status.used_zero)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.hit)
                begin
                    cmd.merge_wr = 1'b1;
                    state_next   = ST_FINISH;
                end
                else if (status.last)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.inc_idx = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_FINISH:
            begin
                // hold until the result register is free
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A match ends the scan straight away
    `ARPR_ASSERT_NEXT(a_hit_ends_scan, (state_reg == ST_CHECK) && status.hit, state_reg == ST_FINISH, "scan continued after a match")

endmodule

`default_nettype wire

FILE: hw/rtl/arpr_dpath.sv
// ----------------------------------------------------------------------------
// ARP receive cache datapath
// Request capture, cache memories, scan compare, entry count and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "arp_receive_cache_update_assert.svh"

module arpr_dpath
    import arpr_pkg::*;
#(
    parameter int CACHE_ENTRIES = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ctrl_cmd_t           cmd,
    output dp_status_t               status,
    input  wire logic [IP_W-1:0]     local_ip,
    input  wire logic [OP_W-1:0]     in_opcode,
    input  wire logic [S_DATA_W-1:0] in_data,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,
    output logic                     m_tuser
);

    localparam int IW = $clog2(CACHE_ENTRIES);
    localparam int CW = $clog2(CACHE_ENTRIES + 1);

    // Cache memories, contents undefined until written
    logic [IP_W-1:0]  mem_ip  [CACHE_ENTRIES];
    logic [MAC_W-1:0] mem_mac [CACHE_ENTRIES];

    logic [OP_W-1:0]  op_reg;
    logic [MAC_W-1:0] smac_reg;
    logic [IP_W-1:0]  sip_reg;
    logic             tip_match_reg;
    logic [IP_W-1:0]  rd_ip_reg;
    logic             merged_reg;
    logic [IW-1:0]    idx_reg;
    logic [IW-1:0]    idx_next;
    logic [CW-1:0]    used_reg;
    logic [CW-1:0]    used_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg;
    logic             m_user_reg;

    logic             full;
    logic             want_insert;
    logic             do_insert;
    logic             do_reply;
    logic             ip_we;
    logic             mac_we;
    logic [IW-1:0]    waddr;

    // Status towards the controller
    always_comb
    begin
        status.op_ok     = (op_reg == OP_REQUEST) || (op_reg == OP_REPLY);
        status.used_zero = (used_reg == '0);
        status.hit       = (rd_ip_reg == sip_reg);
        status.last      = ((CW'(idx_reg) + CW'(1)) == used_reg);
        status.out_free  = !m_valid_reg || m_tready;
    end

    // Insert decision at commit
    always_comb
    begin
        full        = (used_reg == CW'(CACHE_ENTRIES));
        want_insert = status.op_ok && tip_match_reg && !merged_reg;
        do_insert   = cmd.commit && want_insert && !full;
        do_reply    = (op_reg == OP_REQUEST) && tip_match_reg;
        ip_we       = do_insert;
        mac_we      = do_insert || cmd.merge_wr;
        waddr       = cmd.merge_wr ? idx_reg : used_reg[IW-1:0];
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg        <= in_opcode;
            smac_reg      <= in_data[MAC_W-1:0];
            sip_reg       <= in_data[MAC_W +: IP_W];
            tip_match_reg <= (in_data[MAC_W+IP_W +: IP_W] == local_ip);
        end
    end

    // Cache memory write and registered read
    always_ff @(posedge clk)
    begin
        if (ip_we)
        begin
            mem_ip[waddr] <= sip_reg;
        end
        if (mac_we)
        begin
            mem_mac[waddr] <= smac_reg;
        end
        if (cmd.rd_en)
        begin
            rd_ip_reg <= mem_ip[idx_reg];
        end
    end

    // Scan index, entry count and result valid
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load)
        begin
            idx_next = '0;
        end
        else if (cmd.inc_idx)
        begin
            idx_next = idx_reg + IW'(1);
        end

        used_next = used_reg;
        if (do_insert)
        begin
            used_next = used_reg + CW'(1);
        end

        m_valid_next = m_valid_reg;
        if (cmd.commit)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            used_reg    <= '0;
            merged_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg     <= idx_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
            if (cmd.load)
            begin
                merged_reg <= 1'b0;
            end
            else if (cmd.merge_wr)
            begin
                merged_reg <= 1'b1;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            m_user_reg <= do_reply;
            m_data_reg <= {CNT_W'(used_next),
                           want_insert && full,
                           do_insert,
                           merged_reg,
                           do_reply ? sip_reg  : '0,
                           do_reply ? smac_reg : '0};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `ARPR_ASSERT(a_used_bound, used_reg <= CW'(CACHE_ENTRIES), "entry count above cache depth")
    `ARPR_ASSERT(a_merge_xor_ins, !(m_valid_reg && m_data_reg[MAC_W+IP_W] && m_data_reg[MAC_W+IP_W+1]), "result both merged and inserted")
    `ARPR_ASSERT_NEXT(a_insert_count, do_insert, used_reg == $past(used_reg) + CW'(1), "insert did not bump entry count")

endmodule

`default_nettype wire

FILE: bench/arp_result_compare.sv
// ----------------------------------------------------------------------------
// ARP receive cache result comparator
// Watches the request, result and configuration channels of the ARP receive
// cache, keeps its own copy of the cache and local address, works out the
// result each accepted request must give and compares every returned result
// field by field with the oldest one still due.
// ----------------------------------------------------------------------------

module arp_result_compare
    import arpr_pkg::*;
#(
    parameter int CACHE_ENTRIES = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    input  wire logic                s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic [OP_W-1:0]     s_tuser,
    input  wire logic                m_tvalid,
    input  wire logic                m_tready,
    input  wire logic [M_DATA_W-1:0] m_tdata,
    input  wire logic                m_tuser,
    input  wire logic                cfg_we,
    input  wire logic [IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_data,
    output int unsigned              fail_count,
    output int unsigned              pending,
    output int unsigned              results_seen
);

    typedef struct packed {
        logic             reply;
        logic [MAC_W-1:0] target_mac;
        logic [IP_W-1:0]  target_ip;
        logic             merged;
        logic             inserted;
        logic             cache_full;
        logic [CNT_W-1:0] entry_count;
    } arp_result_t;

    // Own copy of the configuration and of the cache
    logic [IP_W-1:0]  local_ip;
    logic [MAC_W-1:0] local_mac;   // not part of any result, tracked all the same
    logic [IP_W-1:0]  cache_ip  [CACHE_ENTRIES];
    logic [MAC_W-1:0] cache_mac [CACHE_ENTRIES];
    int unsigned      used;

    arp_result_t pending_results [$];

    initial begin
        fail_count   = 0;
        pending      = 0;
        results_seen = 0;
    end

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $time, results_seen, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [MAC_W-1:0] got,
                               input logic [MAC_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // RFC 826 receive rule: merge on a sender hit, append when aimed at us
    task automatic receive_packet(input logic [OP_W-1:0] op,
                                  input logic [MAC_W-1:0] smac,
                                  input logic [IP_W-1:0] sip,
                                  input logic [IP_W-1:0] tip,
                                  output arp_result_t res);
        int unsigned idx;
        bit          hit;
        res = '0;
        hit = 1'b0;
        if (op == OP_REQUEST || op == OP_REPLY) begin
            // first match wins; the cache never holds an IP twice
            for (idx = 0; idx < used && !hit; idx++) begin
                if (cache_ip[idx] == sip) begin
                    cache_mac[idx] = smac;
                    hit = 1'b1;
                end
            end
            if (tip == local_ip) begin
                if (!hit) begin
                    if (used < CACHE_ENTRIES) begin
                        cache_ip[used]  = sip;
                        cache_mac[used] = smac;
                        used++;
                        res.inserted = 1'b1;
                    end
                    else begin
                        res.cache_full = 1'b1;
                    end
                end
                // a reply aimed at us never gets answered
                if (op == OP_REQUEST) begin
                    res.reply      = 1'b1;
                    res.target_mac = smac;
                    res.target_ip  = sip;
                end
            end
            res.merged = hit;
        end
        res.entry_count = used[CNT_W-1:0];
    endtask

    // Channel monitor: results first, so a stray result is never masked
    always @(posedge clk) begin : monitor
        arp_result_t got;
        arp_result_t want;
        if (!rst_n) begin
            local_ip  = LOCAL_IP_RST;
            local_mac = LOCAL_MAC_RST;
            used      = 0;
            pending_results.delete();
        end
        else begin
            if (m_tvalid && m_tready) begin
                got.reply       = m_tuser;
                got.target_mac  = m_tdata[MAC_W-1:0];
                got.target_ip   = m_tdata[MAC_W +: IP_W];
                got.merged      = m_tdata[MAC_W+IP_W];
                got.inserted    = m_tdata[MAC_W+IP_W+1];
                got.cache_full  = m_tdata[MAC_W+IP_W+2];
                got.entry_count = m_tdata[MAC_W+IP_W+3 +: CNT_W];
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end
                else begin
                    want = pending_results.pop_front();
                    check_field("reply_valid", got.reply, want.reply);
                    check_field("reply_target_mac", got.target_mac, want.target_mac);
                    check_field("reply_target_ip", got.target_ip, want.target_ip);
                    check_field("merged", got.merged, want.merged);
                    check_field("inserted", got.inserted, want.inserted);
                    check_field("cache_full", got.cache_full, want.cache_full);
                    check_field("entry_count", got.entry_count, want.entry_count);
                end
                results_seen <= results_seen + 1;
            end
            if (s_tvalid && s_tready) begin
                receive_packet(s_tuser, s_tdata[MAC_W-1:0], s_tdata[MAC_W +: IP_W],
                               s_tdata[MAC_W+IP_W +: IP_W], want);
                pending_results.insert(pending_results.size(), want);
            end
            if (cfg_we) begin
                if (cfg_index == REG_LOCAL_IP)
                    local_ip = cfg_data[IP_W-1:0];
                else if (cfg_index == REG_LOCAL_MAC)
                    local_mac = cfg_data[MAC_W-1:0];
            end
        end
        pending <= pending_results.size();
    end

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// ARP receive cache testbench
// Drives parsed ARP packets into the receive cache under several local
// address settings, with random gaps on the request side and random stalls
// on the result side; the comparator beside the block checks every result.
// ----------------------------------------------------------------------------

module tb_top;
    import arpr_pkg::*;

    localparam int          CACHE_ENTRIES   = 16;
    localparam int unsigned PHASE_PACKETS   = 350;
    localparam int unsigned POOL_SIZE       = 20;
    localparam int unsigned WATCHDOG_CYCLES = 5000;
    localparam int unsigned DRAIN_CYCLES    = 2 * CACHE_ENTRIES + 8;

    // Opcodes the block must ignore
    localparam logic [OP_W-1:0] OP_NONE     = 16'h0000;
    localparam logic [OP_W-1:0] OP_RARP_REQ = 16'h0003;
    localparam logic [OP_W-1:0] OP_ALL_ONES = 16'hFFFF;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic [OP_W-1:0]     s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                cfg_we    = 1'b0;
    logic [IDX_W-1:0]    cfg_index = REG_LOCAL_IP;
    logic [CFG_W-1:0]    cfg_data  = '0;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned results_seen;

    int unsigned     live_sent    = 0;
    int unsigned     ignored_sent = 0;
    int unsigned     settings     = 1;
    bit              tx_steady    = 1'b0;
    logic [IP_W-1:0] cur_local_ip = LOCAL_IP_RST;
    logic [IP_W-1:0] known_ips [POOL_SIZE];

    always #1 clk = ~clk;

    arp_receive_cache_update #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    arp_result_compare #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_compare (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    // Idle length: mostly none, some short, a few long
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Present one request after a random gap and wait for its acceptance
    task automatic send_packet(input logic [OP_W-1:0] op, input logic [MAC_W-1:0] mac,
                               input logic [IP_W-1:0] sip, input logic [IP_W-1:0] tip);
        int unsigned gap;
        gap = tx_steady ? 0 : idle_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {tip, sip, mac};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (op == OP_REQUEST || op == OP_REPLY)
            live_sent++;
        else
            ignored_sent++;
    endtask

    // Lower valid and wait until every due result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Write both registers on consecutive edges while the block is idle
    task automatic write_addresses(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LOCAL_IP;
        cfg_data  <= {{(CFG_W-IP_W){1'b0}}, ip};
        @(posedge clk);
        cfg_index <= REG_LOCAL_MAC;
        cfg_data  <= mac;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_local_ip = ip;
        settings++;
    endtask

    // Result side: random stalls, with steady stretches now and then
    always @(posedge clk) begin : rx_drive
        static int unsigned rx_hold  = 0;
        static int unsigned rx_cycle = 0;
        static bit          rx_steady = 1'b0;
        int unsigned        stall;
        rx_cycle = rx_cycle + 1;
        if (rx_cycle % 300 == 0)
            rx_steady = ($urandom_range(0, 3) == 0);
        if (rx_hold != 0) begin
            m_tready <= 1'b0;
            rx_hold  = rx_hold - 1;
        end
        else if (rx_steady) begin
            m_tready <= 1'b1;
        end
        else begin
            stall = idle_len();
            if (stall == 0) begin
                m_tready <= 1'b1;
            end
            else begin
                m_tready <= 1'b0;
                rx_hold  = stall - 1;
            end
        end
    end

    // Watchdog on cycles with no handshake of any kind
    always @(posedge clk) begin : watchdog
        static int unsigned quiet = 0;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet = 0;
        else
            quiet = quiet + 1;
        if (quiet >= WATCHDOG_CYCLES) begin
            $display("Watchdog: no handshake for %0d cycles, %0d results due",
                     quiet, pending);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned      phase;
        int unsigned      r;
        int unsigned      goal;
        logic [OP_W-1:0]  op;
        logic [MAC_W-1:0] mac;
        logic [IP_W-1:0]  sip;
        logic [IP_W-1:0]  tip;

        // Sender address pool: extremes, the reset local address and random ones
        known_ips[0] = '0;
        known_ips[1] = '1;
        known_ips[2] = LOCAL_IP_RST;
        for (r = 3; r < POOL_SIZE; r++)
            known_ips[r] = $urandom;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: ignored opcodes, empty cache, insert, merge, reply to a reply
        send_packet(OP_NONE, '1, '1, cur_local_ip);
        send_packet(OP_ALL_ONES, '0, '0, cur_local_ip);
        send_packet(OP_RARP_REQ, 48'h0123_4567_89AB, 32'h0A00_0001, cur_local_ip);
        send_packet(OP_REPLY, 48'hA5A5_A5A5_A5A5, 32'h0A00_0002, ~cur_local_ip);
        send_packet(OP_REQUEST, '0, '0, cur_local_ip);
        send_packet(OP_REPLY, '1, '1, cur_local_ip);
        send_packet(OP_REQUEST, 48'h5A5A_5A5A_5A5A, '0, ~cur_local_ip);
        send_packet(OP_REQUEST, 48'h0F0F_0F0F_0F0F, '1, cur_local_ip);
        send_packet(OP_RARP_REQ, '1, '0, cur_local_ip);
        send_packet(OP_REQUEST, 48'hFFFF_0000_FFFF, cur_local_ip, cur_local_ip);
        send_packet(OP_REPLY, 48'h0000_FFFF_0000, cur_local_ip, cur_local_ip);

        // Random phases, one per address setting; the cache fills early on
        for (phase = 0; phase < 5; phase++) begin
            if (phase != 0) begin
                drain_results();
                case (phase)
                    1: write_addresses('0, '0);
                    2: write_addresses('1, '1);
                    default: write_addresses($urandom, MAC_W'({$urandom, $urandom}));
                endcase
            end
            goal = live_sent + ignored_sent + PHASE_PACKETS;
            while (live_sent + ignored_sent < goal) begin
                if ((live_sent + ignored_sent) % 64 == 0)
                    tx_steady = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 99);
                if (r < 45)
                    op = OP_REQUEST;
                else if (r < 85)
                    op = OP_REPLY;
                else
                    op = OP_W'($urandom_range(0, 65535));
                mac = MAC_W'({$urandom, $urandom});
                if ($urandom_range(0, 99) < 70)
                    sip = known_ips[$urandom_range(0, POOL_SIZE - 1)];
                else
                    sip = $urandom;
                r = $urandom_range(0, 99);
                if (r < 50)
                    tip = cur_local_ip;
                else if (r < 60)
                    tip = cur_local_ip ^ (32'h1 << $urandom_range(0, IP_W - 1));
                else
                    tip = $urandom;
                send_packet(op, mac, sip, tip);
            end
        end

        // Wind down, then give any stray result time to show up
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d ARP packets and %0d with other opcodes under %0d settings",
                 live_sent, ignored_sent, settings);
        $display("Compared %0d results field by field, %0d mismatches",
                 results_seen, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: arp_receive_cache_update.f
+incdir+hw/rtl
hw/rtl/arpr_pkg.sv
hw/rtl/arpr_ctrl.sv
hw/rtl/arpr_dpath.sv
hw/rtl/arp_receive_cache_update.sv
bench/arp_result_compare.sv
bench/tb_top.sv
